### rtl/imu_cal_pkg.sv
// imu_cal package: payload types, register indexes, status, phase and function enums
`default_nettype none
package imu_cal_pkg;

  localparam int unsigned AXES = 6;
  localparam logic signed [31:0] ONE_G = 32'sd16384;

  typedef enum logic [2:0] {
    REG_MAX_PASSES     = 3'd0,
    REG_BATCH_SIZE     = 3'd1,
    REG_DISCARD_COUNT  = 3'd2,
    REG_ACCEL_DAMPING  = 3'd3,
    REG_ACCEL_DEADZONE = 3'd4,
    REG_GYRO_DEADZONE  = 3'd5
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_ADJUSTED   = 2'd0,
    ST_CALIBRATED = 2'd1,
    ST_GAVE_UP    = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    PH_DISCARD,
    PH_SUM,
    PH_DIV,
    PH_DECIDE,
    PH_DONE
  } phase_e;

  typedef enum logic {
    FUNC_SAMPLE = 1'b0,
    FUNC_LOAD   = 1'b1
  } func_e;

  typedef struct packed {
    logic               func;
    logic [2:0]         axis;
    logic signed [15:0] load_value;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] offset_accel_x;
    logic signed [15:0] offset_accel_y;
    logic signed [15:0] offset_accel_z;
    logic signed [15:0] offset_gyro_x;
    logic signed [15:0] offset_gyro_y;
    logic signed [15:0] offset_gyro_z;
    logic [1:0]         status;
    logic [7:0]         passes_done;
  } out_item_t;

  // control from sequencer, shared by every lane
  typedef struct packed {
    logic clear;
    logic add;
    logic div_start;
    logic adj_start;
  } lane_ctl_t;

endpackage
`default_nettype wire

### rtl/imu_cal_divider.sv
// imu_cal signed restoring divider, one quotient bit per cycle, truncating
`default_nettype none
module imu_cal_divider (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [31:0] dividend_i,
  input  wire logic [12:0]        divisor_i,
  output logic                    busy_o,
  output logic signed [31:0]      quot_o
);
  logic [31:0] rem_q, rem_d, quo_q, quo_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        neg_q, neg_d;
  logic [12:0] dsr_q, dsr_d;
  logic [32:0] trial;

  // shift-subtract step
  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    cnt_d = cnt_q;
    neg_d = neg_q;
    dsr_d = dsr_q;
    trial = '0;
    if (start_i) begin
      neg_d = dividend_i[31];
      quo_d = dividend_i[31] ? 32'(-dividend_i) : 32'(dividend_i);
      rem_d = '0;
      dsr_d = divisor_i;
      cnt_d = 6'd32;
    end else if (cnt_q != 6'd0) begin
      trial = {rem_q, quo_q[31]} - {20'd0, dsr_q};
      if (!trial[32]) begin
        rem_d = trial[31:0];
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = {rem_q[30:0], quo_q[31]};
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    neg_q <= neg_d;
    dsr_q <= dsr_d;
  end

  assign busy_o = (cnt_q != 6'd0);
  assign quot_o = neg_q ? -$signed(quo_q) : $signed(quo_q);
endmodule
`default_nettype wire

### rtl/imu_cal_lane.sv
// imu_cal axis lane: running sum, mean division, deadzone test, offset adjust
`default_nettype none
module imu_cal_lane (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire imu_cal_pkg::lane_ctl_t ctl_i,
  input  wire logic signed [15:0]    sample_i,
  input  wire logic [12:0]           batch_i,
  input  wire logic                  z_first_i,
  input  wire logic [7:0]            divisor_i,
  input  wire logic [7:0]            deadzone_i,
  output logic                       busy_o,
  output logic                       settled_o,
  output logic signed [15:0]         delta_o
);
  import imu_cal_pkg::*;

  logic signed [31:0] sum_q, sum_d;
  logic signed [31:0] mean_q;
  logic               mean_busy, adj_busy, div_busy_q;
  logic signed [31:0] mean_w, adj_w, adj_in;
  logic [31:0]        mag;

  // running sum, emptied when the batch sum moves into the divider
  always_comb begin
    sum_d = sum_q;
    if (ctl_i.clear || ctl_i.div_start) begin
      sum_d = '0;
    end else if (ctl_i.add) begin
      sum_d = sum_q + 32'(sample_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      div_busy_q <= 1'b0;
    end else begin
      sum_q <= sum_d;
      div_busy_q <= mean_busy;
    end
  end

  imu_cal_divider u_mean (
    .clk_i, .rst_ni,
    .start_i    (ctl_i.div_start),
    .dividend_i (sum_q),
    .divisor_i  (batch_i),
    .busy_o     (mean_busy),
    .quot_o     (mean_w)
  );

  // capture mean when divider finishes
  always_ff @(posedge clk_i) begin
    if (div_busy_q && !mean_busy) begin
      mean_q <= mean_w;
    end
  end

  assign adj_in = z_first_i ? (ONE_G - mean_q) : mean_q;

  imu_cal_divider u_adj (
    .clk_i, .rst_ni,
    .start_i    (ctl_i.adj_start),
    .dividend_i (adj_in),
    .divisor_i  ({5'd0, (divisor_i == 8'd0) ? 8'd1 : divisor_i}),
    .busy_o     (adj_busy),
    .quot_o     (adj_w)
  );

  // deadzone compare on magnitude
  assign mag       = mean_q[31] ? 32'(-mean_q) : 32'(mean_q);
  assign settled_o = (mag <= {24'd0, deadzone_i});
  assign delta_o   = adj_w[15:0];
  assign busy_o    = mean_busy | adj_busy | div_busy_q;
endmodule
`default_nettype wire

### rtl/imu_offset_calibration_unit.sv
// imu offset calibration top level: sequencer, six lanes, merge of results
// A sample that does not end a batch is taken without a stall and the next can
// follow at once. After the sample that ends a batch the input is stalled while
// the six lanes divide their sums in parallel with a bit-serial divider to get
// the means, the sequencer decides, and, when the offsets are adjusted, the lanes
// run a second division. The result is then registered in an output register and
// waits there until taken; after an adjusted result samples keep flowing meanwhile,
// but the next batch end holds in its decision state, input stalled, until the
// waiting result leaves. Configuration is taken at once.
`default_nettype none
module imu_offset_calibration_unit #(
  parameter int unsigned MAX_BATCH = 4096
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire imu_cal_pkg::in_item_t  in_data_i,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output imu_cal_pkg::out_item_t      out_data_o,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [2:0]             cfg_index_i,
  input  wire logic [12:0]            cfg_data_i
);
  import imu_cal_pkg::*;

  // counter covers both the batch length and the 10-bit discard count
  localparam int unsigned CW = ($clog2(MAX_BATCH + 1) > 10) ? $clog2(MAX_BATCH + 1) : 10;

  logic [7:0]  max_passes_q, damp_q, adz_q, gdz_q;
  logic [12:0] batch_size_q;
  logic [9:0]  discard_q;
  phase_e      phase_q, phase_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [7:0]  pass_q, pass_d;
  logic signed [15:0] off_q [AXES];
  logic        ovalid_q;
  out_item_t   out_q;
  logic        adj_phase_q, adj_phase_d;
  logic [1:0]  wait_q, wait_d;
  lane_ctl_t   ctl;
  logic        take;
  logic [AXES-1:0] busy, sett;
  logic signed [15:0] delta [AXES];
  logic signed [15:0] smp [AXES];
  logic [CW-1:0] batch_eff;
  logic        all_settled, emit;
  logic [1:0]  emit_status;
  logic        do_adj;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_passes_q <= 8'd20;
      batch_size_q <= 13'd1000;
      discard_q    <= 10'd100;
      damp_q       <= 8'd8;
      adz_q        <= 8'd8;
      gdz_q        <= 8'd1;
    end else if (cfg_valid) begin
      case (cfg_index_i)
        REG_MAX_PASSES:     max_passes_q <= cfg_data_i[7:0];
        REG_BATCH_SIZE:     batch_size_q <= cfg_data_i;
        REG_DISCARD_COUNT:  discard_q    <= cfg_data_i[9:0];
        REG_ACCEL_DAMPING:  damp_q       <= cfg_data_i[7:0];
        REG_ACCEL_DEADZONE: adz_q        <= cfg_data_i[7:0];
        REG_GYRO_DEADZONE:  gdz_q        <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // clamp batch size into 1..MAX_BATCH
  always_comb begin
    if (batch_size_q == 13'd0) begin
      batch_eff = CW'(1);
    end else if (32'(batch_size_q) > MAX_BATCH) begin
      batch_eff = CW'(MAX_BATCH);
    end else begin
      batch_eff = CW'(batch_size_q);
    end
  end

  assign in_stall = (phase_q == PH_DIV) || (phase_q == PH_DECIDE);
  assign take     = in_valid && !in_stall;

  assign smp[0] = in_data_i.accel_x;
  assign smp[1] = in_data_i.accel_y;
  assign smp[2] = in_data_i.accel_z;
  assign smp[3] = in_data_i.gyro_x;
  assign smp[4] = in_data_i.gyro_y;
  assign smp[5] = in_data_i.gyro_z;

  assign all_settled = &sett;

  // next state of the sequencer
  always_comb begin
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    pass_d      = pass_q;
    adj_phase_d = adj_phase_q;
    wait_d      = wait_q;
    case (phase_q)
      PH_DISCARD: begin
        if (take && in_data_i.func == FUNC_SAMPLE) begin
          if (32'(cnt_q) < 32'(discard_q)) begin
            cnt_d = cnt_q + CW'(1);
          end else if (CW'(1) >= batch_eff) begin
            phase_d = PH_DIV;
            cnt_d   = '0;
            wait_d  = 2'd2;
          end else begin
            phase_d = PH_SUM;
            cnt_d   = CW'(1);
          end
        end
      end
      PH_SUM: begin
        if (take && in_data_i.func == FUNC_SAMPLE) begin
          if (cnt_q + CW'(1) >= batch_eff) begin
            phase_d = PH_DIV;
            cnt_d   = '0;
            wait_d  = 2'd2;
          end else begin
            cnt_d = cnt_q + CW'(1);
          end
        end
      end
      PH_DIV: begin
        if (wait_q != 2'd0) begin
          wait_d = wait_q - 2'd1;
        end else if (busy == '0) begin
          phase_d     = PH_DECIDE;
          adj_phase_d = 1'b0;
        end
      end
      PH_DECIDE: begin
        if (!adj_phase_q) begin
          // hold the decision while the previous result still waits
          if (ovalid_q) begin
            phase_d = PH_DECIDE;
          end else if (do_adj) begin
            adj_phase_d = 1'b1;
            wait_d      = 2'd2;
          end else begin
            phase_d = PH_DONE;
          end
        end else if (wait_q != 2'd0) begin
          wait_d = wait_q - 2'd1;
        end else if (busy == '0) begin
          phase_d = PH_DISCARD;
          pass_d  = pass_q + 8'd1;
        end
      end
      PH_DONE: ;
      default: phase_d = PH_DISCARD;
    endcase
    if (take && in_data_i.func == FUNC_LOAD) begin
      phase_d = PH_DISCARD;
      cnt_d   = '0;
      pass_d  = '0;
    end
  end

  // decision at batch end
  always_comb begin
    do_adj      = 1'b0;
    emit_status = ST_GAVE_UP;
    if (pass_q == 8'd0) begin
      do_adj = (max_passes_q != 8'd0);
    end else if (all_settled) begin
      emit_status = ST_CALIBRATED;
    end else if (pass_q < max_passes_q) begin
      do_adj = 1'b1;
    end
    if (do_adj) begin
      emit_status = ST_ADJUSTED;
    end
  end

  // lane control outputs, mean division starts once the last sum is in
  always_comb begin
    ctl           = '0;
    ctl.clear     = take && in_data_i.func == FUNC_LOAD;
    ctl.add       = take && in_data_i.func == FUNC_SAMPLE &&
                    (phase_q == PH_SUM ||
                     (phase_q == PH_DISCARD && 32'(cnt_q) >= 32'(discard_q)));
    ctl.div_start = (phase_q == PH_DIV) && (wait_q == 2'd2);
    ctl.adj_start = (phase_q == PH_DECIDE) && !adj_phase_q && !ovalid_q && do_adj;
  end

  assign emit = ((phase_q == PH_DECIDE) && !adj_phase_q && !ovalid_q && !do_adj) ||
                ((phase_q == PH_DECIDE) && adj_phase_q && wait_q == 2'd0 &&
                 busy == '0);

  // six parallel lanes
  for (genvar k = 0; k < AXES; k++) begin : g_lane
    imu_cal_lane u_lane (
      .clk_i, .rst_ni,
      .ctl_i      (ctl),
      .sample_i   (smp[k]),
      .batch_i    (13'(batch_eff)),
      .z_first_i  (k == 2 && pass_q == 8'd0),
      .divisor_i  ((k < 3) ? damp_q : gdz_q),
      .deadzone_i ((k < 3) ? adz_q : gdz_q),
      .busy_o     (busy[k]),
      .settled_o  (sett[k]),
      .delta_o    (delta[k])
    );
  end

  // offsets: load or merge lane deltas
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < AXES; k++) off_q[k] <= '0;
    end else if (take && in_data_i.func == FUNC_LOAD) begin
      for (int k = 0; k < AXES; k++) begin
        if (in_data_i.axis == 3'(k)) off_q[k] <= in_data_i.load_value;
      end
    end else if (emit && adj_phase_q) begin
      for (int k = 0; k < AXES; k++) off_q[k] <= off_q[k] - delta[k];
    end
  end

  // sequencer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_DISCARD;
      cnt_q       <= '0;
      pass_q      <= '0;
      adj_phase_q <= 1'b0;
      wait_q      <= '0;
    end else begin
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      pass_q      <= pass_d;
      adj_phase_q <= adj_phase_d;
      wait_q      <= wait_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (emit) begin
      ovalid_q <= 1'b1;
    end else if (!out_stall) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q.offset_accel_x <= adj_phase_q ? off_q[0] - delta[0] : off_q[0];
      out_q.offset_accel_y <= adj_phase_q ? off_q[1] - delta[1] : off_q[1];
      out_q.offset_accel_z <= adj_phase_q ? off_q[2] - delta[2] : off_q[2];
      out_q.offset_gyro_x  <= adj_phase_q ? off_q[3] - delta[3] : off_q[3];
      out_q.offset_gyro_y  <= adj_phase_q ? off_q[4] - delta[4] : off_q[4];
      out_q.offset_gyro_z  <= adj_phase_q ? off_q[5] - delta[5] : off_q[5];
      out_q.status         <= adj_phase_q ? ST_ADJUSTED : emit_status;
      out_q.passes_done    <= adj_phase_q ? pass_q + 8'd1 : pass_q;
    end
  end

  assign out_valid  = ovalid_q;
  assign out_data_o = out_q;
endmodule
`default_nettype wire

### rtl/imu_cal_checker.sv
// imu_cal port checker and its bind to the top level
`default_nettype none
module imu_cal_checker (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   in_valid,
  input wire logic                   in_stall,
  input wire logic                   out_valid,
  input wire logic                   out_stall,
  input wire imu_cal_pkg::out_item_t out_data_o
);
  import imu_cal_pkg::*;

  // held result keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_stall |=> $stable(out_data_o))
    else $error("result changed while stalled");

  // a stalled result stays offered
  a_out_keep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // status code is legal
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> out_data_o.status != 2'd3)
    else $error("bad status code");

  // adjusted result always counts at least one pass
  a_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data_o.status == ST_ADJUSTED |-> out_data_o.passes_done != 8'd0)
    else $error("adjusted with zero passes");
endmodule

bind imu_offset_calibration_unit imu_cal_checker u_imu_cal_checker (
  .clk_i, .rst_ni, .in_valid, .in_stall, .out_valid, .out_stall, .out_data_o
);
`default_nettype wire
